FILE: design/fla_pkg.sv
`timescale 1ns / 1ps

package fla_pkg;

	localparam int unsigned IDX_W    = 10;
	localparam int unsigned LINK_W   = 11;
	localparam int unsigned RESULT_W = 11;

	typedef enum logic [1:0] {
		REQ_GET   = 2'd0,
		REQ_PUT   = 2'd1,
		REQ_WRITE = 2'd2,
		REQ_READ  = 2'd3
	} req_type_t;

	localparam logic STATUS_OK        = 1'b0;
	localparam logic STATUS_EXHAUSTED = 1'b1;

	typedef struct packed {
		req_type_t           req_type;
		logic [IDX_W-1:0]    entry_index;
		logic [LINK_W-1:0]   link_value;
	} req_t;

	typedef struct packed {
		logic                status;
		logic [RESULT_W-1:0] result_index;
	} rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic init_wr;
		logic accept;
		logic finish;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic init_last;
		logic out_valid;
	} sts_t;

endpackage

FILE: design/fla_dp.sv
`timescale 1ns / 1ps

module fla_dp #(
	parameter int unsigned CAPACITY = 1024
) (
	input  logic          clk,
	input  logic          arst_n,
	input  fla_pkg::cmd_t cmd,
	input  fla_pkg::req_t req,
	input  logic          rsp_ready,
	output fla_pkg::sts_t sts,
	output fla_pkg::rsp_t rsp
);

	localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned LW = $clog2(CAPACITY + 1);
	localparam logic [LW-1:0] NO_NEXT = LW'(CAPACITY);

	logic [LW-1:0] link_mem [CAPACITY];

	logic [AW-1:0]       init_cnt_q;
	logic [LW-1:0]       head_q;
	logic [LW-1:0]       rdata_q;
	fla_pkg::req_type_t  op_s1;
	logic                empty_s1;
	logic                in_rng_s1;
	logic                out_valid_q;
	fla_pkg::rsp_t       out_q;

	logic          in_rng;
	logic          head_empty;
	logic [AW-1:0] req_addr;
	logic [AW-1:0] rd_addr;
	logic [LW-1:0] link_clamped;
	logic          wr_en;
	logic [LW-1:0] wr_data;

	assign in_rng       = 32'(req.entry_index) < CAPACITY;
	assign head_empty   = head_q == NO_NEXT;
	assign req_addr     = AW'(req.entry_index);
	assign rd_addr      = (req.req_type == fla_pkg::REQ_GET) ? AW'(head_q) : req_addr;
	assign link_clamped = (32'(req.link_value) > CAPACITY) ? NO_NEXT : LW'(req.link_value);

	always_comb begin
		wr_en   = 1'b0;
		wr_data = head_q;
		unique case (req.req_type)
			fla_pkg::REQ_PUT: begin
				wr_en   = cmd.accept && in_rng;
				wr_data = head_q;
			end
			fla_pkg::REQ_WRITE: begin
				wr_en   = cmd.accept && in_rng;
				wr_data = link_clamped;
			end
			default: begin
				wr_en   = 1'b0;
				wr_data = head_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.init_wr) begin
			link_mem[init_cnt_q] <= LW'(init_cnt_q) + LW'(1);
		end else if (wr_en) begin
			link_mem[req_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			rdata_q <= link_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_s1     <= req.req_type;
			empty_s1  <= head_empty;
			in_rng_s1 <= in_rng;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_cnt_q <= '0;
			head_q     <= '0;
		end else begin
			if (cmd.init_wr) begin
				init_cnt_q <= init_cnt_q + AW'(1);
			end
			if (cmd.accept && req.req_type == fla_pkg::REQ_PUT && in_rng) begin
				head_q <= LW'(req.entry_index);
			end else if (cmd.finish && op_s1 == fla_pkg::REQ_GET && !empty_s1) begin
				head_q <= rdata_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_q.status       <= fla_pkg::STATUS_OK;
			out_q.result_index <= '0;
			unique case (op_s1)
				fla_pkg::REQ_GET: begin
					if (empty_s1) begin
						out_q.status <= fla_pkg::STATUS_EXHAUSTED;
					end else begin
						out_q.result_index <= fla_pkg::RESULT_W'(head_q);
					end
				end
				fla_pkg::REQ_READ: begin
					out_q.result_index <= in_rng_s1 ? fla_pkg::RESULT_W'(rdata_q)
					                                : fla_pkg::RESULT_W'(NO_NEXT);
				end
				default: begin
					out_q.result_index <= '0;
				end
			endcase
		end
	end

	assign sts.init_last = init_cnt_q == AW'(CAPACITY - 1);
	assign sts.out_valid = out_valid_q;
	assign rsp           = out_q;

	hd_range: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= NO_NEXT)
		else $error("free head beyond no-next marker");

endmodule

FILE: design/fla_ctrl.sv
`timescale 1ns / 1ps

module fla_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  logic          rsp_ready,
	input  fla_pkg::sts_t sts,
	output logic          req_ready,
	output fla_pkg::cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_INIT = 3'b001,
		ST_IDLE = 3'b010,
		ST_MEM  = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;

	assign req_ready = (state_q == ST_IDLE) && (!sts.out_valid || rsp_ready);

	always_comb begin
		state_d     = state_q;
		cmd.init_wr = 1'b0;
		cmd.accept  = 1'b0;
		cmd.finish  = 1'b0;
		unique case (state_q)
			ST_INIT: begin
				cmd.init_wr = 1'b1;
				if (sts.init_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				cmd.accept = req_valid && req_ready;
				if (cmd.accept) begin
					state_d = ST_MEM;
				end
			end
			ST_MEM: begin
				cmd.finish = 1'b1;
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_INIT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// result slot must be free when a transfer completes its memory cycle
	slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MEM |-> !sts.out_valid)
		else $error("result slot busy at finish");

	acc_to_mem: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> state_q == ST_MEM ##1 sts.out_valid)
		else $error("accepted request did not produce a result");

	init_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_INIT && sts.init_last |=> state_q == ST_IDLE && !sts.out_valid)
		else $error("link init did not end cleanly");

endmodule

FILE: design/free_list_index_allocator.sv
// Free list index allocator.
// Request channel (req_valid/req_ready/req): get an entry, put back an
// entry, write an entry's link or read it. Response channel
// (rsp_valid/rsp_ready/rsp): exactly one response per request, in order,
// with status (exhausted on a get from an empty list) and result_index.
// After reset the block writes the whole link memory (entry i -> i+1,
// last -> no next); req_ready stays low during that sweep.
// For each request, the transfer cycle addresses the single-port link
// memory, and the next cycle uses its registered read data to update the
// free head and load the response register. No new request is taken
// before that; rsp_valid is registered and rises with that load.
// The response register holds until the receiver takes it; a new request
// is taken while the current response is being taken, but not while it
// is stalled, so a stalled receiver stops the request side.
`timescale 1ns / 1ps

module free_list_index_allocator #(
	parameter int unsigned CAPACITY = 1024
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  fla_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output fla_pkg::rsp_t rsp
);

	fla_pkg::cmd_t cmd;
	fla_pkg::sts_t sts;

	fla_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.rsp_ready (rsp_ready),
		.sts       (sts),
		.req_ready (req_ready),
		.cmd       (cmd)
	);

	fla_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.req       (req),
		.rsp_ready (rsp_ready),
		.sts       (sts),
		.rsp       (rsp)
	);

	assign rsp_valid = sts.out_valid;

endmodule
